// ===== rtl/u2w_pkg.sv =====
package u2w_pkg;

    localparam int unsigned U2W_QUEUE_DEPTH = 4;

    localparam int unsigned CODE_W = 21;

    localparam logic [7:0]        LEAD_TWO_MIN   = 8'h80;
    localparam logic [7:0]        LEAD_THREE_MIN = 8'hE0;
    localparam logic [7:0]        LEAD_FOUR_MIN  = 8'hF0;
    localparam logic [5:0]        LEAD_MASK      = 6'h3F;
    localparam logic [CODE_W-1:0] SUPP_MIN       = 21'h10000;
    localparam logic [CODE_W-1:0] HI_SURR_BASE   = 21'h0D800;
    localparam logic [CODE_W-1:0] LO_SURR_BASE   = 21'h0DC00;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              done;
    } t_code_entry;

endpackage

// ===== rtl/u2w_front.sv =====
module u2w_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_end_of_string,
    input  logic                 i_q_full,
    output logic                 o_wr_en,
    output u2w_pkg::t_code_entry o_wr_entry
);
    import u2w_pkg::*;

    logic [CODE_W-1:0] r_acc, n_acc;
    logic [1:0]        r_remaining, n_remaining;
    logic              accept;
    logic [1:0]        extra;
    logic [CODE_W-1:0] code;
    logic              emit;

    assign accept = i_push && !i_q_full;

    always_comb begin
        extra = 2'd0;
        code = '0;
        emit = 1'b0;
        n_acc = r_acc;
        n_remaining = r_remaining;
        if (r_remaining == 2'd0) begin
            if (i_data_byte < LEAD_TWO_MIN) begin
                extra = 2'd0;
            end else if (i_data_byte < LEAD_THREE_MIN) begin
                extra = 2'd1;
            end else if (i_data_byte < LEAD_FOUR_MIN) begin
                extra = 2'd2;
            end else begin
                extra = 2'd3;
            end
            if (extra == 2'd0) begin
                code = {13'd0, i_data_byte};
            end else begin
                code = {15'd0, i_data_byte[5:0] & (LEAD_MASK >> extra)};
            end
            emit = (extra == 2'd0) || i_end_of_string;
            n_remaining = emit ? 2'd0 : extra;
        end else begin
            code = {r_acc[CODE_W-7:0], i_data_byte[5:0]};
            n_remaining = r_remaining - 2'd1;
            emit = (n_remaining == 2'd0) || i_end_of_string;
            if (emit) begin
                n_remaining = 2'd0;
            end
        end
        n_acc = emit ? '0 : code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_remaining <= 2'd0;
        end else if (accept) begin
            r_acc <= n_acc;
            r_remaining <= n_remaining;
        end
    end

    assign o_wr_en = accept && emit;
    assign o_wr_entry.code = code;
    assign o_wr_entry.done = i_end_of_string;

endmodule

// ===== rtl/u2w_queue.sv =====
module u2w_queue #(
    parameter int unsigned DEPTH = u2w_pkg::U2W_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  u2w_pkg::t_code_entry i_wr_entry,
    input  logic                 i_rd_en,
    output u2w_pkg::t_code_entry o_rd_entry,
    output logic                 o_full,
    output logic                 o_empty
);
    import u2w_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_code_entry      r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr, do_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr_en && !o_full;
    assign do_rd   = i_rd_en && !o_empty;
    assign o_rd_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/u2w_back.sv =====
module u2w_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_utf16_mode,
    input  u2w_pkg::t_code_entry i_rd_entry,
    input  logic                 i_q_empty,
    output logic                 o_rd_en,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [20:0]          o_code_unit,
    output logic                 o_last_of_item,
    output logic                 o_string_done
);
    import u2w_pkg::*;

    logic              r_valid;
    logic [CODE_W-1:0] r_code;
    logic              r_last;
    logic              r_done;
    logic              r_pend_valid;
    logic [CODE_W-1:0] r_pend_code;
    logic              r_pend_done;

    logic              out_free;
    logic              split;
    logic [CODE_W-1:0] offset;
    logic [CODE_W-1:0] hi_unit, lo_unit;

    assign out_free = !r_valid || i_pop;
    assign o_rd_en  = out_free && !r_pend_valid && !i_q_empty;
    assign split    = i_utf16_mode && (i_rd_entry.code >= SUPP_MIN);
    assign offset   = i_rd_entry.code - SUPP_MIN;
    assign hi_unit  = HI_SURR_BASE + {10'd0, offset[20:10]};
    assign lo_unit  = LO_SURR_BASE + {11'd0, offset[9:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (out_free) begin
            if (r_pend_valid) begin
                r_valid <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (!i_q_empty) begin
                r_valid <= 1'b1;
                r_pend_valid <= split;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend_valid) begin
                r_code <= r_pend_code;
                r_last <= 1'b1;
                r_done <= r_pend_done;
            end else if (split) begin
                r_code <= hi_unit;
                r_last <= 1'b0;
                r_done <= 1'b0;
                r_pend_code <= lo_unit;
                r_pend_done <= i_rd_entry.done;
            end else begin
                r_code <= i_rd_entry.code;
                r_last <= 1'b1;
                r_done <= i_rd_entry.done;
            end
        end
    end

    assign o_empty        = !r_valid;
    assign o_code_unit    = r_code;
    assign o_last_of_item = r_last;
    assign o_string_done  = r_done;

endmodule

// ===== rtl/utf8_to_wide_decoder_top.sv =====
// UTF-8 to wide code unit decoder.
// Input channel: present a byte on i_data_byte with i_end_of_string and raise push;
// the item is taken at a clock edge where full is low. One byte per cycle is accepted while full is low.
// Result channel: while empty is low the oldest code unit is on o_code_unit with
// o_last_of_item and o_string_done; raise pop to take it.
// A byte that completes a code, or ends the string, is written into a small queue when it
// is accepted; the output stage loads the code from the queue once it is free and all older
// codes have left the queue.
// Throughput is one result per cycle while pop is high, set by the single output register; a
// code that becomes a surrogate pair gives two results, the low one held in a pending register.
// When the receiver stalls, the queue fills and full rises; no item is dropped.
// Reset (synchronous, i_rst_n low) empties the queue and the output stage, closes any
// open sequence and sets UTF-16 mode. The mode register is written with i_cfg_we and
// should only change while no item is in flight.
module utf8_to_wide_decoder_top #(
    parameter int unsigned QUEUE_DEPTH = u2w_pkg::U2W_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_string,
    output logic        empty,
    input  logic        pop,
    output logic [20:0] o_code_unit,
    output logic        o_last_of_item,
    output logic        o_string_done
);
    import u2w_pkg::*;

    logic        r_utf16_mode;
    logic        q_full, q_empty;
    logic        wr_en, rd_en;
    t_code_entry wr_entry, rd_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_utf16_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_utf16_mode <= i_cfg_wdata;
        end
    end

    assign full = q_full;

    u2w_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_data_byte     (i_data_byte),
        .i_end_of_string (i_end_of_string),
        .i_q_full        (q_full),
        .o_wr_en         (wr_en),
        .o_wr_entry      (wr_entry)
    );

    u2w_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_entry (wr_entry),
        .i_rd_en    (rd_en),
        .o_rd_entry (rd_entry),
        .o_full     (q_full),
        .o_empty    (q_empty)
    );

    u2w_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_utf16_mode   (r_utf16_mode),
        .i_rd_entry     (rd_entry),
        .i_q_empty      (q_empty),
        .o_rd_en        (rd_en),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_code_unit    (o_code_unit),
        .o_last_of_item (o_last_of_item),
        .o_string_done  (o_string_done)
    );

endmodule

// ===== test/utf8_to_wide_decoder_checker.sv =====
`timescale 1ns / 1ps

module utf8_to_wide_decoder_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata,
    input  logic                       push,
    input  logic                       full,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_end_of_string,
    input  logic                       empty,
    input  logic                       pop,
    input  logic [u2w_pkg::CODE_W-1:0] i_code_unit,
    input  logic                       i_last_of_item,
    input  logic                       i_string_done,
    output int                         o_fail_count,
    output int                         o_units_pending,
    output int                         o_units_checked
);
    import u2w_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0] code_unit;
        logic              last_of_item;
        logic              string_done;
    } t_wide_unit;

    t_wide_unit        expected_units[$];
    logic              utf16_mode;
    logic [CODE_W-1:0] code_acc;
    logic [1:0]        bytes_left;

    task automatic emit_code(input logic [CODE_W-1:0] code, input logic done);
        logic [CODE_W-1:0] offset;
        offset = code - SUPP_MIN;
        if (utf16_mode && code >= SUPP_MIN) begin
            expected_units.insert(expected_units.size(),
                t_wide_unit'{HI_SURR_BASE + CODE_W'(offset[20:10]), 1'b0, 1'b0});
            expected_units.insert(expected_units.size(),
                t_wide_unit'{LO_SURR_BASE + CODE_W'(offset[9:0]), 1'b1, done});
        end else begin
            expected_units.insert(expected_units.size(), t_wide_unit'{code, 1'b1, done});
        end
    endtask

    task automatic decode_byte(input logic [7:0] data, input logic eos);
        logic [1:0]        extra;
        logic [CODE_W-1:0] code;
        if (bytes_left == 2'd0) begin
            if (data < LEAD_TWO_MIN) begin
                extra = 2'd0;
            end else if (data < LEAD_THREE_MIN) begin
                extra = 2'd1;
            end else if (data < LEAD_FOUR_MIN) begin
                extra = 2'd2;
            end else begin
                extra = 2'd3;
            end
            if (extra == 2'd0) begin
                code = CODE_W'(data);
            end else begin
                code = CODE_W'(data & ({2'b00, LEAD_MASK} >> extra));
            end
            if (extra == 2'd0 || eos) begin
                code_acc   = '0;
                bytes_left = 2'd0;
                emit_code(code, eos);
            end else begin
                code_acc   = code;
                bytes_left = extra;
            end
        end else begin
            code       = {code_acc[CODE_W-7:0], data[5:0]};
            bytes_left = bytes_left - 2'd1;
            if (bytes_left == 2'd0 || eos) begin
                code_acc   = '0;
                bytes_left = 2'd0;
                emit_code(code, eos);
            end else begin
                code_acc = code;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_wide_unit want;
        if (!i_rst_n) begin
            utf16_mode = 1'b1;
            code_acc   = '0;
            bytes_left = 2'd0;
            expected_units.delete();
        end else begin
            if (pop && !empty) begin
                o_units_checked++;
                if (expected_units.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("Unexpected unit %h last %b done %b with nothing pending",
                                 i_code_unit, i_last_of_item, i_string_done);
                    end
                    o_fail_count++;
                end else begin
                    want = expected_units.pop_front();
                    if (want.code_unit !== i_code_unit || want.last_of_item !== i_last_of_item
                            || want.string_done !== i_string_done) begin
                        if (o_fail_count < 10) begin
                            $display("Unit %0d mismatch: expected %h last %b done %b, got %h last %b done %b",
                                     o_units_checked, want.code_unit, want.last_of_item,
                                     want.string_done, i_code_unit, i_last_of_item,
                                     i_string_done);
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                utf16_mode = i_cfg_wdata;
            end
            if (push && !full) begin
                decode_byte(i_data_byte, i_end_of_string);
            end
        end
        o_units_pending = expected_units.size();
    end

endmodule

// ===== test/utf8_to_wide_decoder_top_tb.sv =====
`timescale 1ns / 1ps

module utf8_to_wide_decoder_top_tb;

    import u2w_pkg::*;

    localparam logic MODE_CODE_POINT = 1'b0;
    localparam logic MODE_UTF16      = 1'b1;
    localparam int   CYCLE_LIMIT     = 200000;
    localparam int   LONG_HOLD       = 300;
    localparam int   RANDOM_BYTES    = 550;
    localparam int   DRAIN_CYCLES    = 12;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_wdata;
    logic              push;
    logic              full;
    logic [7:0]        i_data_byte;
    logic              i_end_of_string;
    logic              empty;
    logic              pop;
    logic [CODE_W-1:0] o_code_unit;
    logic              o_last_of_item;
    logic              o_string_done;

    int fail_count;
    int units_pending;
    int units_checked;
    int items_sent;
    int strings_sent;
    int burst_left;
    int cycle_count;
    int hold_left;
    int rx_phase_left;
    int rx_style;
    bit hold_request;
    bit hold_taken;

    utf8_to_wide_decoder_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_end_of_string(i_end_of_string),
        .empty          (empty),
        .pop            (pop),
        .o_code_unit    (o_code_unit),
        .o_last_of_item (o_last_of_item),
        .o_string_done  (o_string_done)
    );

    utf8_to_wide_decoder_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_end_of_string(i_end_of_string),
        .empty          (empty),
        .pop            (pop),
        .i_code_unit    (o_code_unit),
        .i_last_of_item (o_last_of_item),
        .i_string_done  (o_string_done),
        .o_fail_count   (fail_count),
        .o_units_pending(units_pending),
        .o_units_checked(units_checked)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Run timed out after %0d cycles with %0d units outstanding",
                     cycle_count, units_pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The receiver picks a new stall style at the end of each phase of random length and takes
    // one long hold-off when the stimulus asks for it.
    always @(posedge i_clk) begin
        if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
        end
        if (rx_phase_left == 0) begin
            rx_style      = $urandom_range(0, 3);
            rx_phase_left = $urandom_range(20, 120);
        end
        rx_phase_left--;
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            case (rx_style)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                2: pop <= (rx_phase_left % 4) != 0;
                default: pop <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    task automatic send_item(input logic [7:0] data, input logic eos);
        int gap;
        push            <= 1'b1;
        i_data_byte     <= data;
        i_end_of_string <= eos;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_code(input logic [20:0] cp, input int nbytes, input logic eos_last,
                             input int cut);
        logic [7:0] seq[4];
        logic       wild;
        logic       eos;
        wild = ($urandom_range(0, 9) == 0);
        case (nbytes)
            1: seq[0] = {1'b0, cp[6:0]};
            2: begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3: begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default: begin
                seq[0] = {4'hF, wild, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 1; i < nbytes; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                seq[i][7:6] = 2'($urandom_range(0, 3));
            end
        end
        for (int i = 0; i < nbytes; i++) begin
            eos = (i == nbytes - 1) ? eos_last : 1'b0;
            if (i == cut) begin
                send_item(seq[i], 1'b1);
                break;
            end
            send_item(seq[i], eos);
        end
    endtask

    task automatic send_random_string();
        int          n_chars;
        int          cut_char;
        int          nbytes;
        logic [20:0] cp;
        n_chars  = $urandom_range(1, 6);
        cut_char = ($urandom_range(0, 6) == 0) ? $urandom_range(0, n_chars - 1) : -1;
        for (int c = 0; c < n_chars; c++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    nbytes = 1;
                    cp = 21'($urandom_range(0, 'h7F));
                end
                3, 4: begin
                    nbytes = 2;
                    cp = 21'($urandom_range('h80, 'h7FF));
                end
                5, 6: begin
                    nbytes = 3;
                    cp = 21'($urandom_range('h800, 'hFFFF));
                end
                7, 8: begin
                    nbytes = 4;
                    cp = 21'($urandom_range('h10000, 'h1FFFFF));
                end
                default: nbytes = 0;
            endcase
            if (nbytes == 0) begin
                send_item(8'($urandom_range(0, 255)), c == n_chars - 1);
            end else if (c == cut_char) begin
                send_code(cp, nbytes, 1'b1, $urandom_range(0, nbytes - 1));
                break;
            end else begin
                send_code(cp, nbytes, c == n_chars - 1, nbytes);
            end
        end
        strings_sent++;
    endtask

    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (units_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int directed_count;
        push            = 1'b0;
        pop             = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = 1'b0;
        i_data_byte     = 8'h00;
        i_end_of_string = 1'b0;
        i_rst_n         = 1'b0;
        burst_left      = $urandom_range(1, 24);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(8'h00, 1'b1);
        send_item(8'h7F, 1'b0);
        send_item(8'hC3, 1'b0);
        send_item(8'hA9, 1'b0);
        send_item(8'hE2, 1'b0);
        send_item(8'h82, 1'b0);
        send_item(8'hAC, 1'b0);
        send_item(8'hF0, 1'b0);
        send_item(8'h9F, 1'b0);
        send_item(8'h98, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hF4, 1'b0);
        send_item(8'h8F, 1'b0);
        send_item(8'hBF, 1'b0);
        send_item(8'hBF, 1'b0);
        send_item(8'hDF, 1'b0);
        send_item(8'hBF, 1'b1);
        // A string that stops inside a sequence flushes the partial code.
        send_item(8'hE2, 1'b0);
        send_item(8'h82, 1'b1);
        send_item(8'hF0, 1'b1);
        // Stray continuation bytes and 0xF8-0xFF leads are decoded, not rejected.
        send_item(8'h80, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);
        directed_count = items_sent;
        settle();

        for (int phase = 0; phase < 4; phase++) begin
            write_mode((phase % 2 == 0) ? MODE_CODE_POINT : MODE_UTF16);
            if (phase == 1) begin
                hold_request = 1'b1;
                repeat (30) send_item(8'($urandom_range(0, 'h7F)), 1'b0);
            end
            while (items_sent < directed_count + (phase + 1) * RANDOM_BYTES / 4) begin
                send_random_string();
            end
            send_item(8'($urandom_range(0, 255)), 1'b1);
            settle();
        end

        $display("Sent %0d bytes in %0d random strings plus directed cases; checked %0d units.",
                 items_sent, strings_sent, units_checked);
        $display("Both output modes were used and the receiver once held off for %0d cycles.",
                 LONG_HOLD);
        if (fail_count == 0 && units_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
